### src/dpadaq_pkg.sv
package dpadaq_pkg;

    localparam int BTN_W     = 7;
    localparam int ELAPSED_W = 20;
    localparam int CFG_W     = 24;
    localparam int HELD_W    = 25;
    localparam int CFG_IDX_W = 1;
    localparam int MOVE_W    = 2;

    localparam logic [CFG_W-1:0] FIRST_DELAY_RESET = CFG_W'(500000);
    localparam logic [CFG_W-1:0] INTERVAL_RESET    = CFG_W'(100000);
    localparam logic [HELD_W-1:0] HELD_MAX         = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_DELAY = 1'b0,
        CFG_INTERVAL    = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_UP    = 3'd1,
        DIR_DOWN  = 3'd2,
        DIR_LEFT  = 3'd3,
        DIR_RIGHT = 3'd4
    } t_dir;

    localparam int BIT_UP    = 0;
    localparam int BIT_DOWN  = 1;
    localparam int BIT_LEFT  = 2;
    localparam int BIT_RIGHT = 3;
    localparam int BIT_A     = 4;
    localparam int BIT_B     = 5;
    localparam int BIT_START = 6;

    localparam logic signed [MOVE_W-1:0] STEP_NEG  = -2'sd1;
    localparam logic signed [MOVE_W-1:0] STEP_NONE = 2'sd0;
    localparam logic signed [MOVE_W-1:0] STEP_POS  = 2'sd1;

endpackage

### src/dpadaq_in_if.sv
interface dpadaq_in_if
    import dpadaq_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BTN_W-1:0]     buttons;
    logic [ELAPSED_W-1:0] elapsed_us;

    modport source (output valid, output buttons, output elapsed_us, input ready);
    modport sink   (input valid, input buttons, input elapsed_us, output ready);
endinterface

### src/dpadaq_out_if.sv
interface dpadaq_out_if
    import dpadaq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [MOVE_W-1:0] move_x;
    logic signed [MOVE_W-1:0] move_y;
    logic                     restart_pulse;
    logic                     undo_pulse;
    logic                     exit_pulse;

    modport source (output valid, output move_x, output move_y, output restart_pulse,
                    output undo_pulse, output exit_pulse, input ready);
    modport sink   (input valid, input move_x, input move_y, input restart_pulse,
                    input undo_pulse, input exit_pulse, output ready);
endinterface

### src/dpad_autorepeat_qualifier_unit.sv
// Channel    Direction  Payload                                          Handshake
// i_in_ch    in         buttons[6:0], elapsed_us[19:0]                   valid/ready
// o_out_ch   out        move_x, move_y, restart/undo/exit_pulse          valid/ready
// i_cfg_*    in         index[0:0], data[23:0]                           write enable only
//
// One transaction per clock is sustained while the output is not stalled: a frame
// is held in the input register, then the repeat logic (one 25-bit add and two
// compares) updates the hold state as the result enters the output register.
// The synchronous active-low reset clears the hold state and both valid flags
// and restores the default delay and interval.
// A stalled output holds its result; meanwhile only an empty input register refills.
module dpad_autorepeat_qualifier_unit
    import dpadaq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    dpadaq_in_if.sink            i_in_ch,
    dpadaq_out_if.source         o_out_ch
);

    logic [CFG_W-1:0] r_first_delay;
    logic [CFG_W-1:0] r_interval;

    logic                 r_s1_valid;
    logic [BTN_W-1:0]     r_s1_buttons;
    logic [ELAPSED_W-1:0] r_s1_elapsed;

    logic [BTN_W-1:0]  r_last_buttons;
    t_dir              r_last_dir;
    logic              r_repeat_active;
    logic [HELD_W-1:0] r_held;

    logic                     r_out_valid;
    logic signed [MOVE_W-1:0] r_move_x;
    logic signed [MOVE_W-1:0] r_move_y;
    logic                     r_restart;
    logic                     r_undo;
    logic                     r_exit;

    logic out_free;
    logic s1_adv;
    logic in_take;

    t_dir                     dir;
    logic [BTN_W-1:0]         fresh;
    logic                     keep_hold;
    logic                     ra0;
    logic [HELD_W-1:0]        h0;
    logic [HELD_W:0]          sum;
    logic [HELD_W-1:0]        h1;
    logic                     fire_first;
    logic                     ra1;
    logic                     fire;
    logic [HELD_W-1:0]        n_held;
    logic signed [MOVE_W-1:0] n_move_x;
    logic signed [MOVE_W-1:0] n_move_y;

    function automatic t_dir single_dir(input logic [BTN_W-1:0] b);
        t_dir d;
        d = DIR_NONE;
        if (b[BIT_UP] && !b[BIT_DOWN] && !b[BIT_LEFT] && !b[BIT_RIGHT]) begin
            d = DIR_UP;
        end else if (b[BIT_DOWN] && !b[BIT_UP] && !b[BIT_LEFT] && !b[BIT_RIGHT]) begin
            d = DIR_DOWN;
        end else if (b[BIT_LEFT] && !b[BIT_UP] && !b[BIT_DOWN] && !b[BIT_RIGHT]) begin
            d = DIR_LEFT;
        end else if (b[BIT_RIGHT] && !b[BIT_UP] && !b[BIT_DOWN] && !b[BIT_LEFT]) begin
            d = DIR_RIGHT;
        end
        return d;
    endfunction

    assign out_free       = !r_out_valid || o_out_ch.ready;
    assign s1_adv         = r_s1_valid && out_free;
    assign in_take        = i_in_ch.valid && i_in_ch.ready;
    assign i_in_ch.ready  = !r_s1_valid || out_free;

    always_comb begin
        dir        = single_dir(r_s1_buttons);
        fresh      = r_s1_buttons & ~r_last_buttons;
        keep_hold  = (dir != DIR_NONE) && (dir == r_last_dir);
        ra0        = keep_hold ? r_repeat_active : 1'b0;
        h0         = keep_hold ? r_held : '0;
        sum        = {1'b0, h0} + (HELD_W + 1)'(r_s1_elapsed);
        if (dir == DIR_NONE) begin
            h1 = h0;
        end else begin
            h1 = sum[HELD_W] ? HELD_MAX : sum[HELD_W-1:0];
        end
        fire_first = !ra0 && (h1 > HELD_W'(r_first_delay));
        ra1        = ra0 || fire_first;
        fire       = fire_first || (ra1 && (h1 > HELD_W'(r_interval)));
        n_held     = fire ? '0 : h1;
        n_move_x   = STEP_NONE;
        n_move_y   = STEP_NONE;
        if (fire) begin
            case (dir)
                DIR_RIGHT: n_move_x = STEP_POS;
                DIR_LEFT:  n_move_x = STEP_NEG;
                DIR_UP:    n_move_y = STEP_NEG;
                DIR_DOWN:  n_move_y = STEP_POS;
                default:   n_move_x = STEP_NONE;
            endcase
        end else if (fresh[BIT_UP]) begin
            n_move_y = STEP_NEG;
        end else if (fresh[BIT_DOWN]) begin
            n_move_y = STEP_POS;
        end else if (fresh[BIT_LEFT]) begin
            n_move_x = STEP_NEG;
        end else if (fresh[BIT_RIGHT]) begin
            n_move_x = STEP_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_delay <= FIRST_DELAY_RESET;
            r_interval    <= INTERVAL_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FIRST_DELAY: r_first_delay <= i_cfg_data;
                CFG_INTERVAL:    r_interval    <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_s1_valid <= i_in_ch.valid;
        end
        if (in_take) begin
            r_s1_buttons <= i_in_ch.buttons;
            r_s1_elapsed <= i_in_ch.elapsed_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_buttons  <= '0;
            r_last_dir      <= DIR_NONE;
            r_repeat_active <= 1'b0;
            r_held          <= '0;
        end else if (s1_adv) begin
            r_last_buttons  <= r_s1_buttons;
            r_last_dir      <= dir;
            r_repeat_active <= ra1;
            r_held          <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
        if (s1_adv) begin
            r_move_x  <= n_move_x;
            r_move_y  <= n_move_y;
            r_restart <= fresh[BIT_B];
            r_undo    <= fresh[BIT_A];
            r_exit    <= fresh[BIT_START];
        end
    end

    assign o_out_ch.valid         = r_out_valid;
    assign o_out_ch.move_x        = r_move_x;
    assign o_out_ch.move_y        = r_move_y;
    assign o_out_ch.restart_pulse = r_restart;
    assign o_out_ch.undo_pulse    = r_undo;
    assign o_out_ch.exit_pulse    = r_exit;

endmodule

### src/dpadaq_checker.sv
module dpadaq_props
    import dpadaq_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic signed [MOVE_W-1:0] i_move_x,
    input logic signed [MOVE_W-1:0] i_move_y,
    input logic                     i_restart,
    input logic                     i_undo,
    input logic                     i_exit
);

    // A frame moves along at most one axis.
    a_single_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_move_x == STEP_NONE || i_move_y == STEP_NONE))
        else $error("Move on both axes in one transaction.");

    // Each step is zero or a single unit in either direction.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_move_x == STEP_NONE || i_move_x == STEP_POS ||
                          i_move_x == STEP_NEG) &&
                         (i_move_y == STEP_NONE || i_move_y == STEP_POS ||
                          i_move_y == STEP_NEG)))
        else $error("Move step out of range.");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid right after reset.");

    // A result that is not taken stays unchanged.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_move_x) &&
            $stable(i_move_y) && $stable(i_restart) && $stable(i_undo) &&
            $stable(i_exit))
        else $error("Stalled result changed.");

endmodule

bind dpad_autorepeat_qualifier_unit dpadaq_props u_dpadaq_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_move_x    (o_out_ch.move_x),
    .i_move_y    (o_out_ch.move_y),
    .i_restart   (o_out_ch.restart_pulse),
    .i_undo      (o_out_ch.undo_pulse),
    .i_exit      (o_out_ch.exit_pulse)
);
